### hdl/irj_pkg.sv
// irj_pkg: shared types, constants and fixed-point helpers for the reprojection jacobian unit
// used by irj_div, irj_geom, irj_jac and imu_camera_reprojection_jacobian_unit
`default_nettype none
package irj_pkg;

    localparam int DIV_STEPS = 32;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int GEOM_LAT  = 7;

    typedef enum logic [2:0] {
        CFG_ROT_W,
        CFG_ROT_X,
        CFG_ROT_Y,
        CFG_ROT_Z,
        CFG_OFF_X,
        CFG_OFF_Y,
        CFG_OFF_Z
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic signed [31:0] body_x;
        logic signed [31:0] body_y;
        logic signed [31:0] body_z;
        logic signed [31:0] body_qw;
        logic signed [31:0] body_qx;
        logic signed [31:0] body_qy;
        logic signed [31:0] body_qz;
        logic signed [31:0] obs_u;
        logic signed [31:0] obs_v;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] res_val;
        logic signed [31:0] pt_d0;
        logic signed [31:0] pt_d1;
        logic signed [31:0] pt_d2;
        logic signed [31:0] ps_d0;
        logic signed [31:0] ps_d1;
        logic signed [31:0] ps_d2;
        logic signed [31:0] ps_d3;
        logic signed [31:0] ps_d4;
        logic signed [31:0] ps_d5;
        logic               depth_bad;
        logic               last_row;
    } out_beat_t;

    typedef struct packed {
        logic signed [31:0] rot_w;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [31:0] off_x;
        logic signed [31:0] off_y;
        logic signed [31:0] off_z;
    } cam_cfg_t;

    // one projected row: depth, numerator and the jacobian column pairs
    typedef struct packed {
        logic               bad;
        logic               last;
        logic [30:0]        z;
        logic signed [31:0] pcr;
        logic signed [31:0] obs;
        logic [8:0][32:0]   c0;
        logic [8:0][32:0]   c2;
    } row_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // q2.30 product, floor
    function automatic logic signed [34:0] qm(input logic signed [31:0] a,
                                              input logic signed [32:0] b);
        logic signed [64:0] p;
        p = 65'(a) * 65'(b);
        return p[64:30];
    endfunction

endpackage
`default_nettype wire

### hdl/irj_div.sv
// irj_div: pipelined restoring divider, one quotient bit per stage, signed 32 bit saturated result
// depends on irj_pkg
`default_nettype none
module irj_div (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [63:0] num,
    input  logic [30:0]        den,
    output logic signed [31:0] quo
);
    import irj_pkg::*;

    logic [63:0] mag;
    logic        ovf_in;

    logic [30:0] rem_reg [DIV_STEPS+1];
    logic [31:0] lo_reg  [DIV_STEPS+1];
    logic [31:0] q_reg   [DIV_STEPS+1];
    logic [30:0] den_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0] neg_reg;
    logic [DIV_STEPS:0] ovf_reg;
    logic [30:0] rem_next [DIV_STEPS];
    logic [31:0] q_next   [DIV_STEPS];
    logic signed [31:0] quo_reg;
    logic signed [31:0] quo_next;

    assign mag    = num[63] ? 64'(-num) : 64'(num);
    assign ovf_in = mag[63:32] >= {1'b0, den};

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [31:0] t;
        assign t = {rem_reg[k], lo_reg[k][31]};
        always_comb begin
            if (t >= {1'b0, den_reg[k]}) begin
                rem_next[k] = 31'(t - {1'b0, den_reg[k]});
                q_next[k]   = {q_reg[k][30:0], 1'b1};
            end else begin
                rem_next[k] = t[30:0];
                q_next[k]   = {q_reg[k][30:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= rem_next[k];
                q_reg[k+1]   <= q_next[k];
                lo_reg[k+1]  <= {lo_reg[k][30:0], 1'b0};
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    always_comb begin
        if (neg_reg[DIV_STEPS]) begin
            if (ovf_reg[DIV_STEPS] || q_reg[DIV_STEPS] > 32'h8000_0000) begin
                quo_next = 32'sh80000000;
            end else begin
                quo_next = $signed(32'd0 - q_reg[DIV_STEPS]);
            end
        end else begin
            if (ovf_reg[DIV_STEPS] || q_reg[DIV_STEPS][31]) begin
                quo_next = 32'sh7fffffff;
            end else begin
                quo_next = $signed(q_reg[DIV_STEPS]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= mag[62:32];
            lo_reg[0]  <= mag[31:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= num[63];
            ovf_reg[0] <= ovf_in;
            quo_reg    <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

### hdl/irj_geom.sv
// irj_geom: seven stage frame transform, rotation matrices, camera point and jacobian columns
// depends on irj_pkg
`default_nettype none
module irj_geom (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic             in_row,
    input  irj_pkg::in_beat_t in_data,
    input  irj_pkg::cam_cfg_t cfg,
    output logic             out_valid,
    output irj_pkg::row_t    out_row
);
    import irj_pkg::*;

    localparam logic signed [65:0] QONE = 66'sd1 <<< 30;

    logic [GEOM_LAT-1:0] vld_reg;
    logic [GEOM_LAT-1:0] row_reg;
    logic signed [31:0]  obs_reg [GEOM_LAT];

    logic signed [34:0] bq_reg [9];
    logic signed [34:0] cq_reg [9];
    logic signed [31:0] d_reg  [3];
    logic signed [31:0] rwb_reg [9];
    logic signed [31:0] rbc2_reg [9];
    logic signed [31:0] d2_reg [3];
    logic signed [34:0] pip_reg [9];
    logic signed [34:0] rcwp_reg [27];
    logic signed [31:0] rbc3_reg [9];
    logic signed [31:0] pi_reg [3];
    logic signed [31:0] rcw_reg [9];
    logic signed [31:0] rbc4_reg [9];
    logic signed [31:0] e_reg [3];
    logic signed [34:0] jqp_reg [27];
    logic signed [31:0] rcw5_reg [9];
    logic signed [31:0] rbc5_reg [9];
    logic signed [34:0] pcp_reg [9];
    logic signed [31:0] jq_reg [9];
    logic signed [31:0] rcw6_reg [9];
    row_t               out_reg;
    logic signed [32:0] hat [9];

    function automatic logic [8:0][31:0] quat_mat(input logic signed [34:0] p [9]);
        logic [8:0][31:0] m;
        // p: xx yy zz xy xz yz wx wy wz
        m[0] = sat32(QONE - ((66'(p[1]) + 66'(p[2])) <<< 1));
        m[1] = sat32((66'(p[3]) - 66'(p[8])) <<< 1);
        m[2] = sat32((66'(p[4]) + 66'(p[7])) <<< 1);
        m[3] = sat32((66'(p[3]) + 66'(p[8])) <<< 1);
        m[4] = sat32(QONE - ((66'(p[0]) + 66'(p[2])) <<< 1));
        m[5] = sat32((66'(p[5]) - 66'(p[6])) <<< 1);
        m[6] = sat32((66'(p[4]) - 66'(p[7])) <<< 1);
        m[7] = sat32((66'(p[5]) + 66'(p[6])) <<< 1);
        m[8] = sat32(QONE - ((66'(p[0]) + 66'(p[1])) <<< 1));
        return m;
    endfunction

    always_comb begin
        hat[0] = '0;
        hat[1] = -33'(pi_reg[2]);
        hat[2] = 33'(pi_reg[1]);
        hat[3] = 33'(pi_reg[2]);
        hat[4] = '0;
        hat[5] = -33'(pi_reg[0]);
        hat[6] = -33'(pi_reg[1]);
        hat[7] = 33'(pi_reg[0]);
        hat[8] = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[GEOM_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        logic [8:0][31:0]   mb;
        logic [8:0][31:0]   mc;
        logic signed [31:0] pc [3];
        logic signed [31:0] off [3];
        int                 rr;
        if (en) begin
            row_reg    <= {row_reg[GEOM_LAT-2:0], in_row};
            obs_reg[0] <= in_row ? in_data.obs_v : in_data.obs_u;
            for (int n = 1; n < GEOM_LAT; n++) begin
                obs_reg[n] <= obs_reg[n-1];
            end

            // quaternion products
            bq_reg[0] <= qm(in_data.body_qx, 33'(in_data.body_qx));
            bq_reg[1] <= qm(in_data.body_qy, 33'(in_data.body_qy));
            bq_reg[2] <= qm(in_data.body_qz, 33'(in_data.body_qz));
            bq_reg[3] <= qm(in_data.body_qx, 33'(in_data.body_qy));
            bq_reg[4] <= qm(in_data.body_qx, 33'(in_data.body_qz));
            bq_reg[5] <= qm(in_data.body_qy, 33'(in_data.body_qz));
            bq_reg[6] <= qm(in_data.body_qw, 33'(in_data.body_qx));
            bq_reg[7] <= qm(in_data.body_qw, 33'(in_data.body_qy));
            bq_reg[8] <= qm(in_data.body_qw, 33'(in_data.body_qz));
            cq_reg[0] <= qm(cfg.rot_x, 33'(cfg.rot_x));
            cq_reg[1] <= qm(cfg.rot_y, 33'(cfg.rot_y));
            cq_reg[2] <= qm(cfg.rot_z, 33'(cfg.rot_z));
            cq_reg[3] <= qm(cfg.rot_x, 33'(cfg.rot_y));
            cq_reg[4] <= qm(cfg.rot_x, 33'(cfg.rot_z));
            cq_reg[5] <= qm(cfg.rot_y, 33'(cfg.rot_z));
            cq_reg[6] <= qm(cfg.rot_w, 33'(cfg.rot_x));
            cq_reg[7] <= qm(cfg.rot_w, 33'(cfg.rot_y));
            cq_reg[8] <= qm(cfg.rot_w, 33'(cfg.rot_z));
            d_reg[0]  <= sat32(66'(in_data.world_x) - 66'(in_data.body_x));
            d_reg[1]  <= sat32(66'(in_data.world_y) - 66'(in_data.body_y));
            d_reg[2]  <= sat32(66'(in_data.world_z) - 66'(in_data.body_z));

            // rotation matrices
            mb = quat_mat(bq_reg);
            mc = quat_mat(cq_reg);
            for (int n = 0; n < 9; n++) begin
                rwb_reg[n]  <= $signed(mb[n]);
                rbc2_reg[n] <= $signed(mc[n]);
            end
            d2_reg <= d_reg;

            // body point and rcw products
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    pip_reg[i*3+k] <= qm(rwb_reg[k*3+i], 33'(d2_reg[k]));
                    for (int j = 0; j < 3; j++) begin
                        rcwp_reg[(i*3+j)*3+k] <= qm(rbc2_reg[k*3+i], 33'(rwb_reg[j*3+k]));
                    end
                end
            end
            rbc3_reg <= rbc2_reg;

            // sums
            for (int i = 0; i < 3; i++) begin
                pi_reg[i] <= sat32(66'(pip_reg[i*3]) + 66'(pip_reg[i*3+1])
                                   + 66'(pip_reg[i*3+2]));
                for (int j = 0; j < 3; j++) begin
                    rcw_reg[i*3+j] <= sat32(66'(rcwp_reg[(i*3+j)*3])
                                            + 66'(rcwp_reg[(i*3+j)*3+1])
                                            + 66'(rcwp_reg[(i*3+j)*3+2]));
                end
            end
            rbc4_reg <= rbc3_reg;

            // offset and rotation block products
            off[0] = cfg.off_x;
            off[1] = cfg.off_y;
            off[2] = cfg.off_z;
            for (int i = 0; i < 3; i++) begin
                e_reg[i] <= sat32(66'(pi_reg[i]) - 66'(off[i]));
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        jqp_reg[(i*3+j)*3+k] <= qm(rbc4_reg[k*3+i], hat[k*3+j]);
                    end
                end
            end
            rcw5_reg <= rcw_reg;
            rbc5_reg <= rbc4_reg;

            // camera point products, rotation block sums
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    pcp_reg[i*3+k] <= qm(rbc5_reg[k*3+i], 33'(e_reg[k]));
                end
                for (int j = 0; j < 3; j++) begin
                    jq_reg[i*3+j] <= sat32(66'(jqp_reg[(i*3+j)*3])
                                           + 66'(jqp_reg[(i*3+j)*3+1])
                                           + 66'(jqp_reg[(i*3+j)*3+2]));
                end
            end
            rcw6_reg <= rcw5_reg;

            // camera point and row selection
            for (int i = 0; i < 3; i++) begin
                pc[i] = sat32(66'(pcp_reg[i*3]) + 66'(pcp_reg[i*3+1]) + 66'(pcp_reg[i*3+2]));
            end
            rr = row_reg[GEOM_LAT-2] ? 3 : 0;
            out_reg.bad  <= pc[2] <= 32'sd0;
            out_reg.last <= row_reg[GEOM_LAT-2];
            out_reg.z    <= pc[2][30:0];
            out_reg.pcr  <= row_reg[GEOM_LAT-2] ? pc[1] : pc[0];
            out_reg.obs  <= obs_reg[GEOM_LAT-2];
            for (int j = 0; j < 3; j++) begin
                out_reg.c0[j]   <= 33'(rcw6_reg[rr+j]);
                out_reg.c2[j]   <= 33'(rcw6_reg[6+j]);
                out_reg.c0[3+j] <= 33'(jq_reg[rr+j]);
                out_reg.c2[3+j] <= 33'(jq_reg[6+j]);
                out_reg.c0[6+j] <= -33'(rcw6_reg[rr+j]);
                out_reg.c2[6+j] <= -33'(rcw6_reg[6+j]);
            end
        end
    end

    assign out_valid = vld_reg[GEOM_LAT-1];
    assign out_row   = out_reg;

endmodule
`default_nettype wire

### hdl/irj_jac.sv
// irj_jac: projection divide, column numerators and nine column divides into the result beat
// depends on irj_pkg and irj_div
`default_nettype none
module irj_jac (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  irj_pkg::row_t     in_row,
    output logic              out_valid,
    output irj_pkg::out_beat_t out_data
);
    import irj_pkg::*;

    logic signed [31:0] u;
    row_t               sd_reg [DIV_LAT];
    logic [DIV_LAT-1:0] pv_reg;
    row_t               rowd;

    logic signed [64:0] prod_reg [9];
    logic [32:0]        c01_reg [9];
    logic signed [31:0] res1_reg;
    logic [30:0]        z1_reg;
    logic               bad1_reg;
    logic               last1_reg;
    logic               v1_reg;

    logic signed [49:0] g_reg [9];
    logic signed [31:0] res2_reg;
    logic [30:0]        z2_reg;
    logic               bad2_reg;
    logic               last2_reg;
    logic               v2_reg;

    logic signed [31:0] resd_reg [DIV_LAT];
    logic [DIV_LAT-1:0] badd_reg;
    logic [DIV_LAT-1:0] lastd_reg;
    logic [DIV_LAT-1:0] vd_reg;

    logic signed [31:0] qcol [9];
    out_beat_t          out_reg;
    logic               ov_reg;

    irj_div u_proj_div (
        .aclk (aclk),
        .en   (en),
        .num  (64'(in_row.pcr) <<< 16),
        .den  (in_row.z),
        .quo  (u)
    );

    for (genvar j = 0; j < 9; j++) begin : g_col
        irj_div u_col_div (
            .aclk (aclk),
            .en   (en),
            .num  (64'(g_reg[j]) <<< ((j >= 3 && j < 6) ? 16 : 2)),
            .den  (z2_reg),
            .quo  (qcol[j])
        );
    end

    assign rowd = sd_reg[DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vd_reg <= '0;
            ov_reg <= 1'b0;
        end else if (en) begin
            pv_reg <= {pv_reg[DIV_LAT-2:0], in_valid};
            v1_reg <= pv_reg[DIV_LAT-1];
            v2_reg <= v1_reg;
            vd_reg <= {vd_reg[DIV_LAT-2:0], v2_reg};
            ov_reg <= vd_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= in_row;
            for (int n = 1; n < DIV_LAT; n++) begin
                sd_reg[n] <= sd_reg[n-1];
            end

            // u * c2 and residual
            for (int j = 0; j < 9; j++) begin
                prod_reg[j] <= 65'(u) * 65'($signed(rowd.c2[j]));
                c01_reg[j]  <= rowd.c0[j];
            end
            res1_reg  <= sat32(66'(u) - 66'(rowd.obs));
            z1_reg    <= rowd.z;
            bad1_reg  <= rowd.bad;
            last1_reg <= rowd.last;

            // column numerators
            for (int j = 0; j < 9; j++) begin
                g_reg[j] <= 50'($signed(c01_reg[j])) - 50'($signed(prod_reg[j][64:16]));
            end
            res2_reg  <= res1_reg;
            z2_reg    <= z1_reg;
            bad2_reg  <= bad1_reg;
            last2_reg <= last1_reg;

            resd_reg[0] <= res2_reg;
            for (int n = 1; n < DIV_LAT; n++) begin
                resd_reg[n] <= resd_reg[n-1];
            end
            badd_reg  <= {badd_reg[DIV_LAT-2:0], bad2_reg};
            lastd_reg <= {lastd_reg[DIV_LAT-2:0], last2_reg};

            // result beat
            out_reg.last_row  <= lastd_reg[DIV_LAT-1];
            out_reg.depth_bad <= badd_reg[DIV_LAT-1];
            if (badd_reg[DIV_LAT-1]) begin
                out_reg.res_val <= '0;
                out_reg.pt_d0   <= '0;
                out_reg.pt_d1   <= '0;
                out_reg.pt_d2   <= '0;
                out_reg.ps_d0   <= '0;
                out_reg.ps_d1   <= '0;
                out_reg.ps_d2   <= '0;
                out_reg.ps_d3   <= '0;
                out_reg.ps_d4   <= '0;
                out_reg.ps_d5   <= '0;
            end else begin
                out_reg.res_val <= resd_reg[DIV_LAT-1];
                out_reg.pt_d0   <= qcol[0];
                out_reg.pt_d1   <= qcol[1];
                out_reg.pt_d2   <= qcol[2];
                out_reg.ps_d0   <= qcol[3];
                out_reg.ps_d1   <= qcol[4];
                out_reg.ps_d2   <= qcol[5];
                out_reg.ps_d3   <= qcol[6];
                out_reg.ps_d4   <= qcol[7];
                out_reg.ps_d5   <= qcol[8];
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

### hdl/imu_camera_reprojection_jacobian_unit.sv
// imu_camera_reprojection_jacobian_unit: top level, handshake, configuration registers
// depends on irj_pkg, irj_geom, irj_jac (and irj_div below it)
//
// usage:
// - s_valid/s_ready/s_data carry one beat per landmark: world point, body pose
//   (position plus unit quaternion) and the observed normalized image point
// - each input beat yields two result beats on m_valid/m_ready/m_data,
//   the u row (last_row 0) then the v row (last_row 1)
// - the unit takes one input beat per two rows; a row enters the pipeline every
//   cycle unless stalled or s_valid is low, so results leave at one beat per cycle
// - from the first cycle s_valid is seen, the u row passes 7 geometry stages, the
//   projection divider, 2 numerator stages, the column divider bank and the output
//   register before it reaches m_data
// - cfg_we/cfg_index/cfg_data write one camera register per cycle (rotation
//   quaternion w,x,y,z then offset x,y,z); write only while the unit is empty
// - reset (aresetn low, synchronous) clears all valid bits and sets the camera
//   rotation to identity and the offset to zero
// - when m_ready is low with a result beat waiting, the whole pipeline holds
//   and s_ready drops; nothing is lost or repeated
`default_nettype none
module imu_camera_reprojection_jacobian_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  irj_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output irj_pkg::out_beat_t m_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import irj_pkg::*;

    logic     en;
    logic     phase_reg;
    cam_cfg_t cfg_reg;
    logic     geom_valid;
    row_t     geom_row;

    assign en      = !m_valid || m_ready;
    assign s_ready = en && phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else if (en && s_valid) begin
            phase_reg <= !phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rot_w <= 32'sh40000000;
            cfg_reg.rot_x <= '0;
            cfg_reg.rot_y <= '0;
            cfg_reg.rot_z <= '0;
            cfg_reg.off_x <= '0;
            cfg_reg.off_y <= '0;
            cfg_reg.off_z <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ROT_W: cfg_reg.rot_w <= cfg_data;
                CFG_ROT_X: cfg_reg.rot_x <= cfg_data;
                CFG_ROT_Y: cfg_reg.rot_y <= cfg_data;
                CFG_ROT_Z: cfg_reg.rot_z <= cfg_data;
                CFG_OFF_X: cfg_reg.off_x <= cfg_data;
                CFG_OFF_Y: cfg_reg.off_y <= cfg_data;
                CFG_OFF_Z: cfg_reg.off_z <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    irj_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_row    (phase_reg),
        .in_data   (s_data),
        .cfg       (cfg_reg),
        .out_valid (geom_valid),
        .out_row   (geom_row)
    );

    irj_jac u_jac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (geom_valid),
        .in_row    (geom_row),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

endmodule
`default_nettype wire

### sim/irj_checker.sv
`timescale 1ns / 100ps
// irj_checker: predicts the u and v rows of every accepted input beat and compares them
// with the result beats of the reprojection jacobian unit; depends on irj_pkg
`default_nettype none
module irj_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  irj_pkg::in_beat_t       s_data,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  irj_pkg::out_beat_t      m_data,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output int                      fail_count,
    output int                      pending_rows
);
    import irj_pkg::*;

    typedef longint mat3_t [3][3];

    longint cam_q [4];
    longint cam_off [3];
    out_beat_t expected_rows [$];

    function automatic longint fl_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return fl_shr(a * b, 30);
    endfunction

    function automatic void rot_from_quat(longint w, longint x, longint y, longint z,
                                          output mat3_t r);
        longint one, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        one = 64'sd1 << 30;
        xx = qmul(x, x); yy = qmul(y, y); zz = qmul(z, z);
        xy = qmul(x, y); xz = qmul(x, z); yz = qmul(y, z);
        wx = qmul(w, x); wy = qmul(w, y); wz = qmul(w, z);
        r[0][0] = clip32(one - 2 * (yy + zz));
        r[0][1] = clip32(2 * (xy - wz));
        r[0][2] = clip32(2 * (xz + wy));
        r[1][0] = clip32(2 * (xy + wz));
        r[1][1] = clip32(one - 2 * (xx + zz));
        r[1][2] = clip32(2 * (yz - wx));
        r[2][0] = clip32(2 * (xz - wy));
        r[2][1] = clip32(2 * (yz + wx));
        r[2][2] = clip32(one - 2 * (xx + yy));
    endfunction

    function automatic longint jac_entry(longint c0, longint c2, longint u, longint z, int s);
        longint g;
        g = c0 - fl_shr(u * c2, 16);
        return clip32((g * (64'sd1 << s)) / z);
    endfunction

    task automatic predict_rows(input in_beat_t b);
        mat3_t rwb, rbc, rcw, jq, hat;
        longint d [3], pi [3], e [3], pc [3], wp [3], bp [3], obs [2], v [10];
        longint s, z, u;
        out_beat_t o;
        wp[0] = b.world_x; wp[1] = b.world_y; wp[2] = b.world_z;
        bp[0] = b.body_x;  bp[1] = b.body_y;  bp[2] = b.body_z;
        obs[0] = b.obs_u;  obs[1] = b.obs_v;
        rot_from_quat(b.body_qw, b.body_qx, b.body_qy, b.body_qz, rwb);
        rot_from_quat(cam_q[0], cam_q[1], cam_q[2], cam_q[3], rbc);
        for (int i = 0; i < 3; i++) d[i] = clip32(wp[i] - bp[i]);
        for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int k = 0; k < 3; k++) s += qmul(rwb[k][i], d[k]);
            pi[i] = clip32(s);
        end
        for (int i = 0; i < 3; i++) e[i] = clip32(pi[i] - cam_off[i]);
        for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int k = 0; k < 3; k++) s += qmul(rbc[k][i], e[k]);
            pc[i] = clip32(s);
        end
        hat[0][0] = 0;      hat[0][1] = -pi[2]; hat[0][2] = pi[1];
        hat[1][0] = pi[2];  hat[1][1] = 0;      hat[1][2] = -pi[0];
        hat[2][0] = -pi[1]; hat[2][1] = pi[0];  hat[2][2] = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                s = 0;
                for (int k = 0; k < 3; k++) s += qmul(rbc[k][i], rwb[j][k]);
                rcw[i][j] = clip32(s);
                s = 0;
                for (int k = 0; k < 3; k++) s += qmul(rbc[k][i], hat[k][j]);
                jq[i][j] = clip32(s);
            end
        for (int r = 0; r < 2; r++) begin
            for (int i = 0; i < 10; i++) v[i] = 0;
            z = pc[2];
            if (z > 0) begin
                u = clip32((pc[r] * 65536) / z);
                v[0] = clip32(u - obs[r]);
                for (int j = 0; j < 3; j++) begin
                    v[1 + j] = jac_entry(rcw[r][j], rcw[2][j], u, z, 2);
                    v[4 + j] = jac_entry(jq[r][j], jq[2][j], u, z, 16);
                    v[7 + j] = jac_entry(-rcw[r][j], -rcw[2][j], u, z, 2);
                end
            end
            o.res_val = v[0][31:0];
            o.pt_d0 = v[1][31:0]; o.pt_d1 = v[2][31:0]; o.pt_d2 = v[3][31:0];
            o.ps_d0 = v[4][31:0]; o.ps_d1 = v[5][31:0]; o.ps_d2 = v[6][31:0];
            o.ps_d3 = v[7][31:0]; o.ps_d4 = v[8][31:0]; o.ps_d5 = v[9][31:0];
            o.depth_bad = (z <= 0);
            o.last_row = r[0];
            expected_rows.push_back(o);
        end
    endtask

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
            fail_count++;
        end
    endtask

    task automatic check_row(input out_beat_t act);
        out_beat_t ex;
        if (expected_rows.size() == 0) begin
            $error("unexpected result beat");
            fail_count++;
            return;
        end
        ex = expected_rows.pop_front();
        compare_field("res_val", ex.res_val, act.res_val);
        compare_field("pt_d0", ex.pt_d0, act.pt_d0);
        compare_field("pt_d1", ex.pt_d1, act.pt_d1);
        compare_field("pt_d2", ex.pt_d2, act.pt_d2);
        compare_field("ps_d0", ex.ps_d0, act.ps_d0);
        compare_field("ps_d1", ex.ps_d1, act.ps_d1);
        compare_field("ps_d2", ex.ps_d2, act.ps_d2);
        compare_field("ps_d3", ex.ps_d3, act.ps_d3);
        compare_field("ps_d4", ex.ps_d4, act.ps_d4);
        compare_field("ps_d5", ex.ps_d5, act.ps_d5);
        compare_field("depth_bad", 32'(ex.depth_bad), 32'(act.depth_bad));
        compare_field("last_row", 32'(ex.last_row), 32'(act.last_row));
    endtask

    initial begin
        fail_count = 0;
        pending_rows = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            cam_q[0] <= 64'sd1 << 30;
            cam_q[1] <= 0; cam_q[2] <= 0; cam_q[3] <= 0;
            cam_off[0] <= 0; cam_off[1] <= 0; cam_off[2] <= 0;
        end else begin
            if (m_valid && m_ready) check_row(m_data);
            if (s_valid && s_ready) predict_rows(s_data);
            pending_rows <= expected_rows.size();
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ROT_W: cam_q[0] <= $signed(cfg_data);
                    CFG_ROT_X: cam_q[1] <= $signed(cfg_data);
                    CFG_ROT_Y: cam_q[2] <= $signed(cfg_data);
                    CFG_ROT_Z: cam_q[3] <= $signed(cfg_data);
                    CFG_OFF_X: cam_off[0] <= $signed(cfg_data);
                    CFG_OFF_Y: cam_off[1] <= $signed(cfg_data);
                    CFG_OFF_Z: cam_off[2] <= $signed(cfg_data);
                    default: begin
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

### sim/tb_imu_camera_reprojection_jacobian_unit.sv
`timescale 1ns / 100ps
// tb_imu_camera_reprojection_jacobian_unit: stimulus, configuration phases and verdict
// depends on irj_pkg, irj_checker and imu_camera_reprojection_jacobian_unit
`default_nettype none
module tb_imu_camera_reprojection_jacobian_unit;
    import irj_pkg::*;

    localparam int UNIT_LAT = 90;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_beat_t m_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int fail_count;
    int pending_rows;
    int rows_seen = 0;
    int beats_sent = 0;
    bit hold_off = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    imu_camera_reprojection_jacobian_unit dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_we, .cfg_index, .cfg_data
    );

    irj_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending_rows
    );

    always @(posedge aclk) if (m_valid && m_ready) rows_seen++;

    // receiver: random stalls per beat, plus a long hold-off whenever hold_off is set
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                for (int i = 0; i < 400; i++) @(posedge aclk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] small_pos(int lo, int hi);
        return 32'(int'($urandom_range(lo, hi)) <<< 10);
    endfunction

    // mostly well-formed: world point at positive z, near unit quaternion
    function automatic in_beat_t make_beat(bit well_formed);
        in_beat_t b;
        logic [31:0] q [4];
        int k;
        if (!well_formed) begin
            b = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), rand_word()};
            return b;
        end
        for (int i = 0; i < 4; i++) q[i] = 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        k = $urandom_range(0, 3);
        q[k] = $urandom_range(0, 1) ? 32'h40000000 : 32'hc0000000;
        b.world_x = 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
        b.world_y = 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
        b.world_z = small_pos(64, 8000);
        b.body_x = 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        b.body_y = 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        b.body_z = 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        b.body_qw = q[0]; b.body_qx = q[1]; b.body_qy = q[2]; b.body_qz = q[3];
        b.obs_u = $urandom_range(0, 7) == 0 ? rand_word()
                : 32'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
        b.obs_v = $urandom_range(0, 7) == 0 ? rand_word()
                : 32'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
        return b;
    endfunction

    task automatic send_beat(input in_beat_t b, input bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk iff s_ready);
        beats_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk iff pending_rows == 0);
        repeat (UNIT_LAT) @(posedge aclk);
    endtask

    task automatic write_cam(input logic [31:0] qw, qx, qy, qz, ox, oy, oz);
        logic [31:0] vals [7];
        vals = '{qw, qx, qy, qz, ox, oy, oz};
        for (int i = 0; i < 7; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic directed_set();
        in_beat_t b;
        b = '0;
        b.world_z = 32'h00050000;
        b.body_qw = 32'h40000000;
        b.obs_u = 32'h00001000;
        send_beat(b, 1'b0);
        b.world_x = 32'h00010000; b.world_y = 32'hffff0000;
        send_beat(b, 1'b0);
        b.world_z = '0;
        send_beat(b, 1'b1);
        b.world_z = 32'hfffb0000;
        send_beat(b, 1'b0);
        b.world_z = 32'h00000001; b.world_x = 32'h7fffffff;
        send_beat(b, 1'b0);
        b = {12{32'h7fffffff}};
        send_beat(b, 1'b1);
        b = {12{32'h80000000}};
        send_beat(b, 1'b0);
        b = {12{32'hffffffff}};
        send_beat(b, 1'b0);
        b = '0;
        b.world_z = 32'h00020000;
        b.body_qw = 32'h7fffffff; b.body_qx = 32'h7fffffff;
        b.obs_v = 32'h80000000;
        send_beat(b, 1'b0);
        b.body_qw = 32'h80000000; b.body_qx = '0; b.body_qz = 32'h80000000;
        send_beat(b, 1'b1);
        for (int i = 0; i < 10; i++) send_beat(make_beat(1'b1), 1'b0);
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2 && $urandom_range(0, 1) == 0) hold_off = 1'b1;
            send_beat(make_beat($urandom_range(0, 4) != 0), $urandom_range(0, 4) != 0);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_set();
        drain();
        hold_off = 1'b1;
        random_phase(400);
        drain();
        // half-turn camera about x with an offset
        write_cam(32'h0, 32'h40000000, 32'h0, 32'h0, 32'h00008000, 32'hffff8000, 32'h00002000);
        directed_set();
        random_phase(300);
        drain();
        write_cam(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h7fffffff, 32'h80000000, 32'h7fffffff);
        random_phase(200);
        drain();
        write_cam(32'h80000000, 32'h0, 32'h0, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
        random_phase(150);
        drain();
        // slight tilt, still looking forward
        write_cam(32'h3fff0000, 32'h00400000, 32'hffc00000, 32'h00200000,
                  32'h00001000, 32'h00000000, 32'hfffff000);
        random_phase(600);
        drain();
        $display("covered %0d input beats and %0d result rows over five camera setups",
                 beats_sent, rows_seen);
        $display("including depth faults, saturation extremes and a long output stall");
        if (fail_count == 0 && pending_rows == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
